/* design/spq_pkg.sv */
`default_nettype none

package spq_pkg;

    localparam int DEPTH     = 16;
    localparam int TAG_BITS  = 16;
    localparam int PRIO_BITS = 8;
    localparam int CNT_BITS  = $clog2(DEPTH + 1);

    localparam logic       CMD_PUSH = 1'b0;
    localparam logic       CMD_POP  = 1'b1;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    // Contents of one slot of the chain.
    typedef struct packed {
        logic                 occ;
        logic [PRIO_BITS-1:0] prio;
        logic [TAG_BITS-1:0]  tag;
    } slot_t;

    // Operation broadcast to every cell in a cycle.
    typedef struct packed {
        logic                 push;
        logic                 pop;
        logic [PRIO_BITS-1:0] prio;
        logic [TAG_BITS-1:0]  tag;
    } cell_ctrl_t;

endpackage

`default_nettype wire

/* design/stable_priority_queue.sv */
// Stable bounded priority queue built as a chain of slot cells.
// Input channel (in_valid, in_stall, cmd, priority_req, tag) carries one
// command per transfer: a push of a (priority, tag) entry or a pop of the head.
// Output channel (out_valid, out_stall, status, head_valid, head_priority,
// head_tag, entry_count) returns exactly one result per command: its status
// and the head entry and count after the command.
// Results are registered: the result of a command accepted at one edge is valid
// after that edge. Throughput is one command per cycle while the output is
// taken; every cell updates in parallel from its neighbors, so the chain
// itself never limits the rate.
// Smaller priority values leave first; equal priorities leave in arrival order.
// A push into a full queue is dropped with status 1, a pop of an empty queue
// returns status 2, and the queue is left unchanged in both cases.
// Reset empties the queue and clears the output register; no clearing pass
// is needed, so a command can be accepted right after reset.
// While the receiver stalls a valid result, the result holds and in_stall is
// raised; a new command is accepted in the same cycle the held result leaves.
`default_nettype none

module stable_priority_queue (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    output logic                                 in_stall,
    input  wire logic                            cmd,
    input  wire logic [spq_pkg::PRIO_BITS-1:0]   priority_req,
    input  wire logic [spq_pkg::TAG_BITS-1:0]    tag,
    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output logic [1:0]                           status,
    output logic                                 head_valid,
    output logic [spq_pkg::PRIO_BITS-1:0]        head_priority,
    output logic [spq_pkg::TAG_BITS-1:0]         head_tag,
    output logic [spq_pkg::CNT_BITS-1:0]         entry_count
);

    localparam int DEPTH = spq_pkg::DEPTH;

    logic                          accept;
    logic                          full;
    logic                          empty;
    spq_pkg::cell_ctrl_t           ctrl;
    spq_pkg::slot_t                slots [DEPTH];
    logic [DEPTH-1:0]              keeps;
    logic [DEPTH-1:0]              occ_vec;

    logic                          out_valid_reg;
    logic                          out_valid_next;
    logic [1:0]                    status_reg;
    logic [1:0]                    status_next;
    logic [spq_pkg::CNT_BITS-1:0]  count_reg;
    logic [spq_pkg::CNT_BITS-1:0]  count_next;

    // The output register is the only thing that can hold the input back.
    assign in_stall = out_valid_reg && out_stall;
    assign accept   = in_valid && !in_stall;

    assign full  = (count_reg == spq_pkg::CNT_BITS'(DEPTH));
    assign empty = (count_reg == '0);

    // Every cell sees the same operation; a rejected command moves nothing.
    always_comb
    begin
        ctrl.push = accept && (cmd == spq_pkg::CMD_PUSH) && !full;
        ctrl.pop  = accept && (cmd == spq_pkg::CMD_POP) && !empty;
        ctrl.prio = priority_req;
        ctrl.tag  = tag;
    end

    // Cell 0 is the head. On a push a cell takes the new entry when its left
    // neighbor stays and it does not, and takes the left neighbor's entry when
    // both move; on a pop every cell takes its right neighbor's entry.
    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            spq_pkg::slot_t left_slot;
            spq_pkg::slot_t right_slot;
            logic           left_keep;

            if (gi == 0)
            begin : g_first
                assign left_slot = '0;
                assign left_keep = 1'b1;
            end
            else
            begin : g_mid
                assign left_slot = slots[gi-1];
                assign left_keep = keeps[gi-1];
            end

            if (gi == DEPTH - 1)
            begin : g_last
                assign right_slot = '0;
            end
            else
            begin : g_inner
                assign right_slot = slots[gi+1];
            end

            spq_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctrl       (ctrl),
                .left_slot  (left_slot),
                .left_keep  (left_keep),
                .right_slot (right_slot),
                .slot       (slots[gi]),
                .keep       (keeps[gi])
            );

            assign occ_vec[gi] = slots[gi].occ;
        end
    endgenerate

    always_comb
    begin
        count_next     = count_reg;
        status_next    = status_reg;
        out_valid_next = out_valid_reg;
        if (accept)
        begin
            out_valid_next = 1'b1;
            if (cmd == spq_pkg::CMD_PUSH)
            begin
                if (full)
                begin
                    status_next = spq_pkg::ST_FULL;
                end
                else
                begin
                    status_next = spq_pkg::ST_OK;
                    count_next  = count_reg + 1'b1;
                end
            end
            else
            begin
                if (empty)
                begin
                    status_next = spq_pkg::ST_EMPTY;
                end
                else
                begin
                    status_next = spq_pkg::ST_OK;
                    count_next  = count_reg - 1'b1;
                end
            end
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            status_reg    <= spq_pkg::ST_OK;
            count_reg     <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            status_reg    <= status_next;
            count_reg     <= count_next;
        end
    end

    // The cells only change on an accepted command, so the head read straight
    // from cell 0 stays stable while a result is stalled.
    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign head_valid    = slots[0].occ;
    assign head_priority = slots[0].occ ? slots[0].prio : '0;
    assign head_tag      = slots[0].occ ? slots[0].tag : '0;
    assign entry_count   = count_reg;

`ifndef NO_ASSERTIONS
    // The count tracks the number of occupied cells.
    a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(occ_vec) == 32'(count_reg))
        else $error("entry count differs from occupied cells");

    // Occupied cells always form a run starting at the head.
    a_occ_prefix: assert property (@(posedge clk) disable iff (!rst_n)
        ((occ_vec + 1'b1) & occ_vec) == '0)
        else $error("occupied cells are not contiguous from the head");

    // A dropped push leaves the count at full depth.
    a_full_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && cmd == spq_pkg::CMD_PUSH && full) |=>
        (count_reg == spq_pkg::CNT_BITS'(DEPTH) && status_reg == spq_pkg::ST_FULL))
        else $error("push into full queue changed the count");

    // A valid result never carries the unused status code.
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (status_reg == spq_pkg::ST_OK ||
                           status_reg == spq_pkg::ST_FULL ||
                           status_reg == spq_pkg::ST_EMPTY))
        else $error("result carries an undefined status");
`endif

endmodule

`default_nettype wire

/* design/spq_cell.sv */
`default_nettype none

module spq_cell (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire spq_pkg::cell_ctrl_t ctrl,
    input  wire spq_pkg::slot_t     left_slot,
    input  wire logic               left_keep,
    input  wire spq_pkg::slot_t     right_slot,
    output spq_pkg::slot_t          slot,
    output logic                    keep
);

    spq_pkg::slot_t slot_reg;
    spq_pkg::slot_t slot_next;

    // This cell stays put on a push when it holds an entry that is not worse
    // than the new one, so equal priorities keep their arrival order.
    assign keep = slot_reg.occ && (slot_reg.prio <= ctrl.prio);
    assign slot = slot_reg;

    always_comb
    begin
        slot_next = slot_reg;
        if (ctrl.push)
        begin
            if (!keep)
            begin
                if (left_keep)
                begin
                    slot_next.occ  = 1'b1;
                    slot_next.prio = ctrl.prio;
                    slot_next.tag  = ctrl.tag;
                end
                else
                begin
                    slot_next = left_slot;
                end
            end
        end
        else if (ctrl.pop)
        begin
            slot_next = right_slot;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg <= '0;
        end
        else
        begin
            slot_reg <= slot_next;
        end
    end

endmodule

`default_nettype wire
